// File: rtl/crse_pkg.sv
// ----------------------------------------------------------------------------
// crse_pkg
// Shared widths, codes and elaboration helpers for the Catmull-Rom segment
// evaluator.
// ----------------------------------------------------------------------------
package crse_pkg;

   // Field widths of the request and response channels
   localparam int OpW       = 2;
   localparam int CoordW    = 20;   // signed Q12.8
   localparam int SegW      = 7;
   localparam int StepW     = 7;
   localparam int StatW     = 2;
   localparam int CountOutW = 8;

   // Default sizing of the point table and the sample grid
   localparam int MaxPointsDef = 128;
   localparam int SamplesDef   = 100;

   // Knot ratio table: one entry per segment, ratios clamp past FibCap
   localparam int RomDepth = 128;
   localparam int FibCap   = 40;
   localparam int RatioW   = 16;   // unsigned Q2.14
   localparam int UW       = 16;   // unsigned Q0.16

   // Datapath widths
   localparam int PointW = 2 * CoordW;   // {x, y}
   localparam int DiffW  = CoordW + 1;   // chord
   localparam int MW     = 24;           // tangent, Q.8
   localparam int TW     = 28;           // Horner accumulator, Q.8
   localparam int MulBW  = RatioW + 2;   // signed view of ratio or u
   localparam int ProdW  = TW + MulBW;   // shared multiplier product

   typedef enum logic [OpW-1:0] {
      OP_APPEND = 2'd0,
      OP_EVAL   = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [StatW-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL_CP,
      ST_MUL_CN,
      ST_M1,
      ST_MUL_C3,
      ST_HORNER1,
      ST_MUL_T1,
      ST_HORNER2,
      ST_MUL_T2,
      ST_FINAL,
      ST_DONE
   } state_type;

   // Knot spacing dt_j: 1 for j <= 2, then Fibonacci. Elaboration only.
   function automatic longint fib_spacing(input int j);
      longint a;
      longint b;
      longint t;
      a = 1;
      b = 1;
      for (int n = 3; n <= j; n++) begin
         t = a + b;
         a = b;
         b = t;
      end
      return b;
   endfunction

endpackage

// File: rtl/catmull_rom_segment_eval_core.sv
// ----------------------------------------------------------------------------
// catmull_rom_segment_eval_core
// Control point table with a non-uniform Catmull-Rom sample evaluator.
// ----------------------------------------------------------------------------
// Requests append a point, clear the table or evaluate one curve sample on
// segment i at u = k/SAMPLES; every request gives exactly one response with
// the current point count. The block works on one request at a time. Append,
// clear, bad or unused requests hold the request side through the done state
// only. A valid evaluate takes the request, then holds the request side while
// it makes four reads of the point memory (one read per cycle, with registered
// read data), then runs each coordinate, x and then y, through a sequence
// around the one shared 28x18 multiplier (two tangent products, three Horner
// products, and the rounding steps between them), then hands the result to the
// output register in the done state. That state repeats while the output
// register still holds a stalled response. A finished response waits in the
// output register while the next request is taken. The point memory has no
// reset; it is only read below the stored count.
module catmull_rom_segment_eval_core #(
   parameter int MAX_POINTS = crse_pkg::MaxPointsDef,
   parameter int SAMPLES    = crse_pkg::SamplesDef
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [crse_pkg::OpW-1:0]             req_opcode,
   input  logic signed [crse_pkg::CoordW-1:0]   req_point_x,
   input  logic signed [crse_pkg::CoordW-1:0]   req_point_y,
   input  logic [crse_pkg::SegW-1:0]            req_segment_index,
   input  logic [crse_pkg::StepW-1:0]           req_sample_step,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [crse_pkg::CoordW-1:0]   rsp_curve_x,
   output logic signed [crse_pkg::CoordW-1:0]   rsp_curve_y,
   output logic [crse_pkg::StatW-1:0]           rsp_status,
   output logic [crse_pkg::CountOutW-1:0]       rsp_point_count
);
   import crse_pkg::*;

   localparam int AddrW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CntW   = $clog2(MAX_POINTS + 1);
   localparam int CmpW   = (CntW > SegW + 1) ? CntW : SegW + 1;
   localparam int RdCntW = 3;
   localparam logic [RdCntW-1:0] RdLast = 3'd4;   // four reads, last capture

   localparam logic signed [ProdW-1:0] RndQ15 = ProdW'(1 << 14);
   localparam logic signed [ProdW-1:0] RndQ16 = ProdW'(1 << 15);
   localparam logic signed [TW-1:0] CoordMax = TW'((1 << (CoordW - 1)) - 1);
   localparam logic signed [TW-1:0] CoordMin = TW'(-(1 << (CoordW - 1)));

   // ------------------------------------------------------------------------
   // Constant tables: knot ratios per segment, u per sample step
   // ------------------------------------------------------------------------
   logic [2*RatioW-1:0] ratio_rom [RomDepth];
   logic [UW-1:0]       u_rom     [RomDepth];

   for (genvar g = 0; g < RomDepth; g++) begin : g_rom
      localparam int     R      = (g < FibCap) ? g : FibCap;
      localparam longint Cur    = (R == 0) ? 1 : fib_spacing(R);
      localparam longint Prev   = (R <= 1) ? 1 : fib_spacing(R - 1);
      localparam longint Next   = fib_spacing(R + 1);
      localparam longint RatioP = ((Cur << 14) + Prev / 2) / Prev;
      localparam longint RatioN = ((Cur << 14) + Next / 2) / Next;
      localparam longint UVal   = (longint'(g) * 65536 + longint'(SAMPLES / 2)) / SAMPLES;
      assign ratio_rom[g] = {RatioW'(RatioP), RatioW'(RatioN)};
      assign u_rom[g]     = UW'(UVal);
   end

   // ------------------------------------------------------------------------
   // Declarations
   // ------------------------------------------------------------------------
   state_type             state_ff, state_in;
   logic [CntW-1:0]       count_ff;
   logic [RdCntW-1:0]     rd_cnt_ff;
   logic                  dim_ff;
   logic [SegW-1:0]       seg_ff;
   logic [UW-1:0]         u_ff;
   logic [RatioW-1:0]     rp_ff, rn_ff;
   logic [PointW-1:0]     p_ff [4];
   logic [PointW-1:0]     point_mem [MAX_POINTS];
   logic [PointW-1:0]     mem_q_ff;
   logic signed [ProdW-1:0] prod_ff;
   logic signed [MW-1:0]  m0_ff, m1_ff;
   logic signed [TW-1:0]  c2_ff, t_ff;
   logic signed [CoordW-1:0] res_x_ff, res_y_ff;
   status_type            pend_status_ff;

   logic                  rsp_valid_ff;
   logic signed [CoordW-1:0] rsp_curve_x_ff, rsp_curve_y_ff;
   logic [StatW-1:0]      rsp_status_ff;
   logic [CountOutW-1:0]  rsp_point_count_ff;

   op_type                op;
   logic                  req_accept;
   logic                  seg_ok;
   logic                  table_full;
   logic                  mem_we;
   logic                  out_free;
   logic                  out_load;
   logic [CmpW-1:0]       rd_sum;
   logic [AddrW-1:0]      rd_addr;
   logic signed [CoordW-1:0] p0, p1, p2, p3;
   logic signed [DiffW-1:0]  cp, c, cn;
   logic signed [ProdW-1:0]  c_sh, m_sum;
   logic signed [MW-1:0]     m_new;
   logic signed [TW-1:0]     c_t, c2_new, c3_new, hr, fin, fin_sat;
   logic signed [TW-1:0]     mul_a;
   logic signed [MulBW-1:0]  mul_b;

   // ------------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------------
   assign op         = op_type'(req_opcode);
   assign req_accept = req_valid && !req_stall;
   assign table_full = (count_ff >= CntW'(MAX_POINTS));
   assign seg_ok     = (req_segment_index != '0)
                    && ((CmpW'(req_segment_index) + CmpW'(2)) < CmpW'(count_ff))
                    && ({1'b0, req_sample_step} < (StepW + 1)'(SAMPLES));
   assign mem_we     = req_accept && (op == OP_APPEND) && !table_full;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------------
   // Sequencer: state register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer: next state, handshake and multiplier operand select
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      out_load  = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (op == OP_EVAL && seg_ok) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            if (rd_cnt_ff == RdLast) begin
               state_in = ST_MUL_CP;
            end
         end
         ST_MUL_CP: begin
            mul_a    = TW'(cp);
            mul_b    = $signed({2'b00, rp_ff});
            state_in = ST_MUL_CN;
         end
         ST_MUL_CN: begin
            mul_a    = TW'(cn);
            mul_b    = $signed({2'b00, rn_ff});
            state_in = ST_M1;
         end
         ST_M1: begin
            state_in = ST_MUL_C3;
         end
         ST_MUL_C3: begin
            mul_a    = c3_new;
            mul_b    = $signed({2'b00, u_ff});
            state_in = ST_HORNER1;
         end
         ST_HORNER1: begin
            state_in = ST_MUL_T1;
         end
         ST_MUL_T1: begin
            mul_a    = t_ff;
            mul_b    = $signed({2'b00, u_ff});
            state_in = ST_HORNER2;
         end
         ST_HORNER2: begin
            state_in = ST_MUL_T2;
         end
         ST_MUL_T2: begin
            mul_a    = t_ff;
            mul_b    = $signed({2'b00, u_ff});
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            state_in = dim_ff ? ST_DONE : ST_MUL_CP;
         end
         ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Point count and read/coordinate counters
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_cnt_ff <= '0;
         dim_ff    <= 1'b0;
      end else begin
         if (req_accept) begin
            rd_cnt_ff <= '0;
            dim_ff    <= 1'b0;
            case (op)
               OP_APPEND: begin
                  if (!table_full) begin
                     count_ff <= count_ff + CntW'(1);
                  end
               end
               OP_CLEAR: begin
                  count_ff <= '0;
               end
               default: begin
               end
            endcase
         end
         if (state_ff == ST_READ) begin
            rd_cnt_ff <= rd_cnt_ff + RdCntW'(1);
         end
         if (state_ff == ST_FINAL) begin
            dim_ff <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Point memory: one write (append), one registered read
   // ------------------------------------------------------------------------
   assign rd_sum  = CmpW'(seg_ff) + CmpW'(rd_cnt_ff) - CmpW'(1);
   assign rd_addr = rd_sum[AddrW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         point_mem[count_ff[AddrW-1:0]] <= {req_point_x, req_point_y};
      end
      mem_q_ff <= point_mem[rd_addr];
   end

   // ------------------------------------------------------------------------
   // Arithmetic on the current coordinate (x when dim_ff is low)
   // ------------------------------------------------------------------------
   assign p0 = dim_ff ? $signed(p_ff[0][CoordW-1:0]) : $signed(p_ff[0][PointW-1:CoordW]);
   assign p1 = dim_ff ? $signed(p_ff[1][CoordW-1:0]) : $signed(p_ff[1][PointW-1:CoordW]);
   assign p2 = dim_ff ? $signed(p_ff[2][CoordW-1:0]) : $signed(p_ff[2][PointW-1:CoordW]);
   assign p3 = dim_ff ? $signed(p_ff[3][CoordW-1:0]) : $signed(p_ff[3][PointW-1:CoordW]);

   // chords
   assign cp = DiffW'(p1) - DiffW'(p0);
   assign c  = DiffW'(p2) - DiffW'(p1);
   assign cn = DiffW'(p3) - DiffW'(p2);

   // tangent: (chord * 2^14 + ratio product) rounded by 2^15
   assign c_sh  = ProdW'(c) <<< 14;
   assign m_sum = prod_ff + c_sh + RndQ15;
   assign m_new = MW'(m_sum >>> 15);

   // Hermite coefficients
   assign c_t    = TW'(c);
   assign c2_new = (c_t <<< 1) + c_t - (TW'(m0_ff) <<< 1) - TW'(m1_ff);
   assign c3_new = TW'(m0_ff) + TW'(m1_ff) - (c_t <<< 1);

   // product with u rounded to Q.8, half toward plus infinity
   assign hr = TW'((prod_ff + RndQ16) >>> 16);

   // final sum and saturation
   assign fin     = TW'(p1) + hr;
   assign fin_sat = (fin > CoordMax) ? CoordMax : ((fin < CoordMin) ? CoordMin : fin);

   // ------------------------------------------------------------------------
   // Datapath registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      prod_ff <= ProdW'(mul_a) * ProdW'(mul_b);

      if (req_accept) begin
         seg_ff   <= req_segment_index;
         u_ff     <= u_rom[req_sample_step];
         rp_ff    <= ratio_rom[req_segment_index][2*RatioW-1:RatioW];
         rn_ff    <= ratio_rom[req_segment_index][RatioW-1:0];
         res_x_ff <= '0;
         res_y_ff <= '0;
         case (op)
            OP_APPEND: begin
               pend_status_ff <= table_full ? STAT_FULL : STAT_OK;
            end
            OP_EVAL: begin
               pend_status_ff <= seg_ok ? STAT_OK : STAT_RANGE;
            end
            default: begin
               pend_status_ff <= STAT_OK;
            end
         endcase
      end

      // capture read data in the cycle after its address
      if (state_ff == ST_READ && rd_cnt_ff != '0) begin
         p_ff[rd_cnt_ff[1:0] - 2'd1] <= mem_q_ff;
      end

      case (state_ff)
         ST_MUL_CN: begin
            m0_ff <= m_new;
         end
         ST_M1: begin
            m1_ff <= m_new;
         end
         ST_MUL_C3: begin
            c2_ff <= c2_new;
         end
         ST_HORNER1: begin
            t_ff <= c2_ff + hr;
         end
         ST_HORNER2: begin
            t_ff <= TW'(m0_ff) + hr;
         end
         ST_FINAL: begin
            if (dim_ff) begin
               res_y_ff <= CoordW'(fin_sat);
            end else begin
               res_x_ff <= CoordW'(fin_sat);
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_curve_x_ff     <= res_x_ff;
         rsp_curve_y_ff     <= res_y_ff;
         rsp_status_ff      <= pend_status_ff;
         rsp_point_count_ff <= CountOutW'(count_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_curve_x     = rsp_curve_x_ff;
   assign rsp_curve_y     = rsp_curve_y_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_point_count = rsp_point_count_ff;

endmodule
